@@ sv/wnm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_pkg
// Shared types, codes and defaults for the windowed neighbor maximum block.
// ----------------------------------------------------------------------------
package wnm_pkg;

  // parameter defaults
  localparam int SERIES_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int HALF_MAX_DEF     = 63;

  // fixed field widths
  localparam int POS_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 6;
  localparam int HALF_CW   = 6;
  localparam int DIR_W     = 2;
  localparam int BND_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY   = 2'd2;

  // neighbourhood codes
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BOTH  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_ALL   = 2'd3;

  // edge handling codes (any other code discards)
  localparam logic [BND_W-1:0] BND_REFLECT = 2'd0;
  localparam logic [BND_W-1:0] BND_WRAP    = 2'd1;
  localparam logic [BND_W-1:0] BND_DISCARD = 2'd2;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // reset values of the registers
  localparam logic [HALF_CW-1:0] HALF_RST = 6'd1;
  localparam logic [DIR_W-1:0]   DIR_RST  = DIR_ALL;
  localparam logic [BND_W-1:0]   BND_RST  = BND_REFLECT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST
  } wnm_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic query_init;
    logic reject;
    logic issue;
    logic finish;
  } wnm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic query_ok;
    logic last_issue;
  } wnm_status_t;

endpackage
`default_nettype wire

@@ sv/windowed_neighbor_maximum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_neighbor_maximum
// Stores a sample series and answers neighbourhood maximum queries.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+------------------
//  request  | kind_i first_i sample_i position_i           | start & !busy
//  result   | max_value_o valid_res_o                      | res_strobe_o
//  config   | cfg_idx_i cfg_data_i                         | cfg_we_i
//
//  A load is taken while busy stays low. A query that is refused
//  (position or window outside the series, discarded edge) gives its result
//  in the next cycle. An accepted query reads one stored sample per cycle
//  through the single read port: h or 2h+1 reads, then the last state folds
//  in the last read. busy stays high through the scan and the last state,
//  the result strobe comes in the cycle busy drops, and only then can the
//  next request be taken.
//  After reset the series is empty and the registers hold half width 1, all
//  neighbours with centre, reflected edges. Results cannot be stalled.
// ----------------------------------------------------------------------------
module windowed_neighbor_maximum #(
  parameter int SERIES_DEPTH = wnm_pkg::SERIES_DEPTH_DEF,
  parameter int SAMPLE_BITS  = wnm_pkg::SAMPLE_BITS_DEF,
  parameter int HALF_MAX     = wnm_pkg::HALF_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wnm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [wnm_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind_i,
  input  wire logic                          first_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic [wnm_pkg::POS_W-1:0]     position_i,
  output logic                               res_strobe_o,
  output logic [SAMPLE_BITS-1:0]             max_value_o,
  output logic                               valid_res_o
);
  import wnm_pkg::*;

  wnm_cmd_t    cmd;
  wnm_status_t status;

  // sequencer
  wnm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // storage and arithmetic
  wnm_dpath #(
    .SERIES_DEPTH (SERIES_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .HALF_MAX     (HALF_MAX)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .first_i      (first_i),
    .sample_i     (sample_i),
    .position_i   (position_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .max_value_o  (max_value_o),
    .valid_res_o  (valid_res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
`default_nettype wire

@@ sv/wnm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_ctrl
// Sequencer: takes requests, runs the window scan and triggers the result.
// ----------------------------------------------------------------------------
module wnm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire logic                 kind_i,
  input  wire wnm_pkg::wnm_status_t status_i,
  output wnm_pkg::wnm_cmd_t         cmd_o,
  output logic                      busy
);
  import wnm_pkg::*;

  wnm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (status_i.query_ok) begin
            cmd_o.query_init = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.reject = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // checks
  a_last_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST |=> state_q == ST_IDLE)
    else $error("last read not followed by idle");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.last_issue) |=> state_q == ST_LAST)
    else $error("scan did not stop at last read");

  a_cmd_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.query_init, cmd_o.reject, cmd_o.issue, cmd_o.finish}))
    else $error("more than one command at a time");

endmodule
`default_nettype wire

@@ sv/wnm_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wnm_dpath
// Sample store, configuration, window index walker and running maximum.
// ----------------------------------------------------------------------------
module wnm_dpath #(
  parameter int SERIES_DEPTH = wnm_pkg::SERIES_DEPTH_DEF,
  parameter int SAMPLE_BITS  = wnm_pkg::SAMPLE_BITS_DEF,
  parameter int HALF_MAX     = wnm_pkg::HALF_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wnm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [wnm_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire logic                          first_i,
  input  wire logic [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic [wnm_pkg::POS_W-1:0]     position_i,
  input  wire wnm_pkg::wnm_cmd_t             cmd_i,
  output wnm_pkg::wnm_status_t               status_o,
  output logic [SAMPLE_BITS-1:0]             max_value_o,
  output logic                               valid_res_o,
  output logic                               res_strobe_o
);
  import wnm_pkg::*;

  localparam int AW  = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
  localparam int CW  = $clog2(SERIES_DEPTH + 1);
  localparam int HW  = (HALF_MAX > 1) ? $clog2(HALF_MAX + 1) : 1;
  localparam int MW0 = (CW > POS_W) ? CW : POS_W;
  localparam int MW  = (MW0 > HW) ? MW0 : HW;
  localparam int UW  = MW + 1;
  localparam int JW  = UW + 1;
  localparam int KW  = HW + 2;

  // configuration registers
  logic [HALF_CW-1:0] half_q;
  logic [DIR_W-1:0]   dir_q;
  logic [BND_W-1:0]   bnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_RST;
      dir_q  <= DIR_RST;
      bnd_q  <= BND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_WIDTH: half_q <= cfg_data_i[HALF_CW-1:0];
        REG_DIRECTION:  dir_q  <= cfg_data_i[DIR_W-1:0];
        REG_BOUNDARY:   bnd_q  <= cfg_data_i[BND_W-1:0];
        default: ;
      endcase
    end
  end

  // series length
  logic [CW-1:0] len_q;
  logic          wr_ok;
  logic [AW-1:0] wr_addr;

  assign wr_ok   = first_i || (len_q < CW'(SERIES_DEPTH));
  assign wr_addr = first_i ? '0 : len_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.load && wr_ok) begin
      len_q <= first_i ? CW'(1) : len_q + CW'(1);
    end
  end

  // clamped half width
  logic [HW-1:0] h_c;

  always_comb begin
    if (half_q == '0) begin
      h_c = HW'(1);
    end else if (int'(half_q) > HALF_MAX) begin
      h_c = HW'(HALF_MAX);
    end else begin
      h_c = HW'(half_q);
    end
  end

  // query admission
  logic [UW-1:0] n_u, p_u, h_u;
  logic          discard;

  assign n_u     = UW'(len_q);
  assign p_u     = UW'(position_i);
  assign h_u     = UW'(h_c);
  assign discard = (bnd_q != BND_REFLECT) && (bnd_q != BND_WRAP);

  assign status_o.query_ok = (p_u < n_u) && (h_u < n_u) &&
                             !(discard && ((p_u < h_u) || (p_u + h_u >= n_u)));

  // window walker
  logic signed [JW-1:0] n_s, p_s, h_s;
  logic signed [JW-1:0] j_q, ctr_q, n2m2_q;
  logic [KW-1:0]        cnt_q;
  logic                 skip_ctr_q;

  assign n_s = $signed(JW'(len_q));
  assign p_s = $signed(JW'(position_i));
  assign h_s = $signed(JW'(h_c));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.query_init) begin
      cnt_q <= ((dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT)) ? KW'(h_c)
                                                             : KW'({h_c, 1'b1});
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q - KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_init) begin
      j_q        <= (dir_q == DIR_RIGHT) ? p_s + JW'(1) : p_s - h_s;
      ctr_q      <= p_s;
      n2m2_q     <= n_s + n_s - JW'(2);
      skip_ctr_q <= (dir_q == DIR_BOTH);
    end else if (cmd_i.issue) begin
      j_q <= j_q + JW'(1);
    end
  end

  assign status_o.last_issue = (cnt_q == KW'(1));

  // edge mapping of the window index
  logic signed [JW-1:0] map_s;
  logic                 wrap;

  assign wrap = (bnd_q == BND_WRAP);

  always_comb begin
    if (j_q[JW-1]) begin
      map_s = wrap ? j_q + n_s : -j_q;
    end else if (j_q >= n_s) begin
      map_s = wrap ? j_q - n_s : n2m2_q - j_q;
    end else begin
      map_s = j_q;
    end
  end

  // sample store
  logic [SAMPLE_BITS-1:0] mem [SERIES_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem[wr_addr] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[map_s[AW-1:0]];
    end
  end

  // read tracking
  logic rd_vld_q, use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      use_q    <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      use_q    <= !(skip_ctr_q && (j_q == ctr_q));
    end
  end

  // running maximum
  logic [SAMPLE_BITS-1:0] acc_q, acc_d;
  logic                   any_q, take;

  assign take  = rd_vld_q && use_q;
  assign acc_d = (take && (!any_q || ($signed(rdata_q) > $signed(acc_q)))) ? rdata_q
                                                                           : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (cmd_i.query_init) begin
      any_q <= 1'b0;
    end else if (take) begin
      any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // result registers
  logic                   res_stb_q, res_valid_q;
  logic [SAMPLE_BITS-1:0] res_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stb_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_stb_q <= cmd_i.finish || cmd_i.reject;
      if (cmd_i.finish) begin
        res_valid_q <= any_q || take;
      end else if (cmd_i.reject) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_max_q <= (any_q || take) ? acc_d : '0;
    end else if (cmd_i.reject) begin
      res_max_q <= '0;
    end
  end

  assign max_value_o  = res_max_q;
  assign valid_res_o  = res_valid_q;
  assign res_strobe_o = res_stb_q;

  // checks
  a_stb_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_stb_q |-> $past(cmd_i.finish || cmd_i.reject))
    else $error("result strobe without finish or reject");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> cnt_q != '0)
    else $error("read issued with empty window count");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (res_valid_q && res_stb_q))
    else $error("scanned window gave no valid maximum");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(SERIES_DEPTH))
    else $error("series length beyond store depth");

endmodule
`default_nettype wire

@@ bench/nbr_max_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_max_checker
// Watches the request, result and register ports of the windowed neighbor
// maximum block, keeps its own copy of the series and the registers, works
// out the maximum that each query should return and compares every result
// strobe against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module nbr_max_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wnm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [wnm_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          kind_i,
  input  wire logic                          first_i,
  input  wire logic [wnm_pkg::SAMPLE_BITS_DEF-1:0] sample_i,
  input  wire logic [wnm_pkg::POS_W-1:0]     position_i,
  input  wire logic                          res_strobe_o,
  input  wire logic [wnm_pkg::SAMPLE_BITS_DEF-1:0] max_value_o,
  input  wire logic                          valid_res_o,
  output int                                 mismatch_count_o,
  output int                                 due_count_o
);
  import wnm_pkg::*;

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int DEPTH     = SERIES_DEPTH_DEF;

  typedef struct packed {
    logic signed [SW-1:0] peak;
    logic                 ok;
  } nbr_result_t;

  // local copy of the series and the registers
  logic signed [SW-1:0] held_samples [DEPTH];
  int                   held = 0;
  logic [HALF_CW-1:0]   half_q = HALF_RST;
  logic [DIR_W-1:0]     dir_q = DIR_RST;
  logic [BND_W-1:0]     bnd_q = BND_RST;

  // answers owed by the block, oldest first
  nbr_result_t peaks_due [$];

  // maximum over the selected neighbourhood of one position
  function automatic nbr_result_t neighbor_peak(input logic [POS_W-1:0] pos);
    int                   n;
    int                   p;
    int                   h;
    int                   lo;
    int                   hi;
    int                   idx;
    bit                   edge_drop;
    bit                   skip;
    bit                   seen;
    logic signed [SW-1:0] best;
    nbr_result_t          r;
    r = '0;
    n = held;
    p = int'(pos);
    h = int'(half_q);
    if (h == 0) h = 1;
    if (h > HALF_MAX_DEF) h = HALF_MAX_DEF;
    // beyond the series or window too wide
    if (p >= n || h >= n) return r;
    // unused boundary code behaves as discard
    edge_drop = (bnd_q != BND_REFLECT) && (bnd_q != BND_WRAP);
    if (edge_drop && (p < h || p + h >= n)) return r;
    lo = (dir_q == DIR_RIGHT) ? p + 1 : p - h;
    hi = (dir_q == DIR_LEFT) ? p - 1 : p + h;
    seen = 1'b0;
    best = '0;
    for (int j = lo; j <= hi; j++) begin
      if (dir_q == DIR_BOTH && j == p) continue;
      skip = 1'b0;
      if (bnd_q == BND_WRAP) begin
        idx = (j + n) % n;
      end else if (j < 0) begin
        idx = -j;
        skip = edge_drop;
      end else if (j >= n) begin
        idx = 2 * (n - 1) - j;
        skip = edge_drop;
      end else begin
        idx = j;
      end
      if (!skip && (!seen || held_samples[idx] > best)) begin
        best = held_samples[idx];
        seen = 1'b1;
      end
    end
    r.ok = seen;
    r.peak = seen ? best : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    mismatch_count_o++;
  endtask

  // compare results first, then take register writes and requests
  always @(posedge clk_i or negedge rst_ni) begin
    nbr_result_t want;
    if (!rst_ni) begin
      held = 0;
      half_q = HALF_RST;
      dir_q = DIR_RST;
      bnd_q = BND_RST;
      peaks_due.delete();
      due_count_o <= 0;
    end else begin
      if (res_strobe_o === 1'b1) begin
        if (peaks_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: max %0d valid %b",
                                    $signed(max_value_o), valid_res_o));
        end else begin
          want = peaks_due[0];
          peaks_due.delete(0);
          if (max_value_o !== want.peak || valid_res_o !== want.ok)
            report_mismatch($sformatf("max %0d valid %b, wanted max %0d valid %b",
                                      $signed(max_value_o), valid_res_o,
                                      want.peak, want.ok));
        end
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          REG_HALF_WIDTH: half_q = cfg_data_i[HALF_CW-1:0];
          REG_DIRECTION:  dir_q = cfg_data_i[DIR_W-1:0];
          REG_BOUNDARY:   bnd_q = cfg_data_i[BND_W-1:0];
          default: ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (kind_i == KIND_LOAD) begin
          if (first_i) held = 0;
          // a full store ignores the load
          if (held < DEPTH) begin
            held_samples[held] = sample_i;
            held = held + 1;
          end
        end else begin
          peaks_due.insert(peaks_due.size(), neighbor_peak(position_i));
        end
      end
      due_count_o <= peaks_due.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives load and query requests and register writes into the windowed
// neighbor maximum block with random idle cycles, first a directed set of
// edge cases and then random phases of fresh series and queries, ending
// with a run that fills the whole store. Results are checked by
// nbr_max_checker; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import wnm_pkg::*;

  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int DEPTH      = SERIES_DEPTH_DEF;
  // random requests; the directed set and the full-store run bring the
  // total to about 1300
  localparam int RAND_ITEMS = 240;
  localparam int SETTLE     = 8;
  localparam int QUIET_MAX  = 3000;

  // codes the package leaves unnamed
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [BND_W-1:0]     BND_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0]    cfg_data_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 kind_i = KIND_LOAD;
  logic                 first_i = 1'b0;
  logic [SW-1:0]        sample_i = '0;
  logic [POS_W-1:0]     position_i = '0;
  logic                 res_strobe_o;
  logic [SW-1:0]        max_value_o;
  logic                 valid_res_o;
  int                   mismatches;
  int                   peaks_owed;

  bit steady = 1'b1;
  int sent = 0;
  int held_n = 0;
  int quiet = 0;

  windowed_neighbor_maximum dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy),
    .kind_i(kind_i), .first_i(first_i), .sample_i(sample_i), .position_i(position_i),
    .res_strobe_o(res_strobe_o), .max_value_o(max_value_o), .valid_res_o(valid_res_o)
  );

  nbr_max_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy),
    .kind_i(kind_i), .first_i(first_i), .sample_i(sample_i), .position_i(position_i),
    .res_strobe_o(res_strobe_o), .max_value_o(max_value_o), .valid_res_o(valid_res_o),
    .mismatch_count_o(mismatches), .due_count_o(peaks_owed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_strobe_o || cfg_we_i) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // extremes often, small values and full range otherwise
  function automatic logic [SW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return {1'b1, {(SW-1){1'b0}}};
    if (r < 20) return {1'b0, {(SW-1){1'b1}}};
    if (r < 35) return SW'($urandom_range(0, 8) - 4);
    return SW'($urandom);
  endfunction

  // random idle cycles with junk on the request fields
  task automatic sender_gap();
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) begin
        start <= 1'b0;
        kind_i <= 1'($urandom);
        first_i <= 1'($urandom);
        sample_i <= SW'($urandom);
        position_i <= POS_W'($urandom);
        @(posedge clk_i);
      end
    end
  endtask

  // hold a request until the block takes it
  task automatic push_request(input logic kind, input logic first, input logic [SW-1:0] s,
                              input logic [POS_W-1:0] pos);
    sender_gap();
    start <= 1'b1;
    kind_i <= kind;
    first_i <= first;
    sample_i <= s;
    position_i <= pos;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic load_sample(input logic first, input logic [SW-1:0] s);
    push_request(KIND_LOAD, first, s, POS_W'($urandom));
    if (first) held_n = 0;
    if (held_n < DEPTH) held_n++;
  endtask

  // queries carry junk in first and sample
  task automatic ask(input int pos);
    push_request(KIND_QUERY, 1'($urandom), SW'($urandom), POS_W'(pos));
  endtask

  // wait until every answer is in and the block has gone quiet
  task automatic settle_block();
    start <= 1'b0;
    @(negedge clk_i);
    while (peaks_owed != 0 || busy) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // junk in the unused upper data bits, sometimes a write to the spare index
  task automatic write_config(input int half, input logic [DIR_W-1:0] dir,
                              input logic [BND_W-1:0] bnd);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_HALF_WIDTH;
    cfg_data_i <= CFG_DW'(half);
    @(posedge clk_i);
    cfg_idx_i <= REG_DIRECTION;
    cfg_data_i <= {junk[3:0], dir};
    @(posedge clk_i);
    cfg_idx_i <= REG_BOUNDARY;
    cfg_data_i <= {junk[7:4], bnd};
    @(posedge clk_i);
    if (junk[10:8] == 3'd0) begin
      cfg_idx_i <= REG_SPARE;
      cfg_data_i <= junk[21:16];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int r;
    int len;
    int nq;
    int half;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, empty series, one sample
    ask(0);
    load_sample(1'b1, {1'b1, {(SW-1){1'b0}}});
    ask(0);
    load_sample(1'b0, {1'b0, {(SW-1){1'b1}}});
    load_sample(1'b0, SW'('h5A5A));
    load_sample(1'b0, '1);
    load_sample(1'b0, '0);
    // reflected edges, positions beyond the series
    ask(0);
    ask(4);
    ask(2);
    ask(5);
    ask(1023);
    // zero half width, left side only
    settle_block();
    write_config(0, DIR_LEFT, BND_REFLECT);
    ask(1);
    ask(0);
    // right side with periodic wrap
    settle_block();
    write_config(1, DIR_RIGHT, BND_WRAP);
    ask(4);
    ask(0);
    // both sides without centre, unused boundary code discards
    settle_block();
    write_config(1, DIR_BOTH, BND_SPARE);
    ask(0);
    ask(2);
    ask(4);
    settle_block();
    write_config(2, DIR_ALL, BND_DISCARD);
    ask(2);
    ask(1);
    // restart the series
    load_sample(1'b1, SW'(7));
    ask(3);

    // random phases: new registers, often a fresh series, then queries
    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle_block();
      steady = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) half = 0;
      else if (r < 24) half = HALF_MAX_DEF;
      else if (r < 70) half = $urandom_range(1, 4);
      else half = $urandom_range(1, 20);
      write_config(half, DIR_W'($urandom_range(0, 3)), BND_W'($urandom_range(0, 3)));
      if (held_n == 0 || $urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 24);
        else if (r < 88) len = $urandom_range(25, 80);
        else len = $urandom_range(127, 200);
        for (int k = 0; k < len; k++) load_sample(k == 0, pick_sample());
      end
      nq = $urandom_range(6, 24);
      for (int k = 0; k < nq; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) load_sample(1'b0, pick_sample());
        else if (r < 8) load_sample(1'b1, pick_sample());
        else if (r < 84) ask($urandom_range(0, (held_n + 1 > 1023) ? 1023 : held_n + 1));
        else ask($urandom_range(0, 1023));
      end
    end

    // fill the whole store, push past it, then restart while full
    settle_block();
    steady = 1'b1;
    write_config(HALF_MAX_DEF, DIR_ALL, BND_WRAP);
    for (int k = 0; k < DEPTH + 3; k++) load_sample(k == 0, pick_sample());
    ask(1023);
    ask(1000);
    ask(0);
    ask(511);
    load_sample(1'b1, pick_sample());
    load_sample(1'b0, pick_sample());
    load_sample(1'b0, pick_sample());
    settle_block();
    write_config(1, DIR_ALL, BND_REFLECT);
    ask(0);
    ask(1);
    ask(2);

    settle_block();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/wnm_pkg.sv
sv/wnm_ctrl.sv
sv/wnm_dpath.sv
sv/windowed_neighbor_maximum.sv
bench/nbr_max_checker.sv
bench/tb.sv
